### hw/rtl/ppr_pkg.sv
// Shared constants, types and the rank fold step for the partial permutation ranker.
package ppr_pkg;

  // Board geometry
  localparam int CELLS      = 16;
  localparam int NIB        = 4;
  localparam int TILE_SLOTS = 1 << NIB;
  localparam int BOARD_W    = 64;
  localparam int CELL_W     = NIB;

  // Result and configuration widths
  localparam int RANK_W = 45;
  localparam int K_W    = 5;
  localparam int BASE_W = $clog2(CELLS + 1);

  // Pipeline shape: one decode stage, one digit stage, then the fold stages
  localparam int STEPS_PER_STAGE = 2;
  localparam int HSTAGES         = (CELLS + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
  localparam int NST             = 2 + HSTAGES;

  typedef logic [CELL_W-1:0]             cell_t;
  typedef logic [RANK_W-1:0]             rank_t;
  typedef logic [K_W-1:0]                grp_size_t;
  typedef logic [CELLS-1:0][CELL_W-1:0]  digit_vec_t;

  // Configuration register indexes
  typedef enum logic {
    CFG_GROUP_TILES = 1'b0,
    CFG_GROUP_SIZE  = 1'b1
  } cfg_reg_t;

  // One Horner step: scale by the base of this position and add its digit,
  // or leave the rank alone past the end of the group
  function automatic rank_t horner_step(rank_t rank, cell_t digit, int unsigned step,
                                        grp_size_t k);
    logic [RANK_W+BASE_W-1:0] prod;
    prod = '0;
    if (K_W'(step) < k) begin
      prod = rank * BASE_W'(CELLS - step);
      horner_step = prod[RANK_W-1:0] + RANK_W'(digit);
    end else begin
      horner_step = rank;
    end
  endfunction

endpackage

### hw/rtl/partial_permutation_rank.sv
// Pipelined pattern-database ranker for a sixteen-cell sliding-tile board.
//
// Input channel: board_state with in_valid / in_stall; one board per transfer,
// cell p held in nibble p. Output channel: group_rank and bad_state with
// out_valid / out_stall; exactly one result per board, in order.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 = the
// sixteen group tile numbers, 1 = group size k, saturated to sixteen). Write
// only while no board is in flight.
// The pipeline is ten register stages deep. One stage locates every tile,
// one stage forms all Lehmer digits in parallel, and eight stages fold two
// digits each into the mixed-radix rank. Throughput is one board per cycle
// while the output does not stall; every stage has its own valid bit and load
// enable, so bubbles close up and a new board is taken whenever the first
// stage is free, even while a finished result waits at the output.
// When the receiver stalls, the result register holds and stall propagates
// backwards only through occupied stages; nothing is dropped or repeated.
// Reset empties the pipeline, clears the tile list and sets the group size to 1.
module partial_permutation_rank import ppr_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [0:0]         cfg_index,
  input  logic [BOARD_W-1:0] cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [BOARD_W-1:0] board_state,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [RANK_W-1:0]  group_rank,
  output logic               bad_state
);

  // Configuration registers
  logic [BOARD_W-1:0] tile_list;
  grp_size_t          pattern_len;
  grp_size_t          k_eff;

  // Pipeline control
  logic [NST-1:0] vld;
  logic [NST-1:0] en;

  // Decode stage
  cell_t          cell_of_next [TILE_SLOTS];
  logic           bad_next;
  cell_t          s1_cell_of [TILE_SLOTS];
  logic           s1_bad;

  // Digit stage
  digit_vec_t     digit_next;
  digit_vec_t     s2_digit;
  logic           s2_bad;

  // Fold stages
  rank_t          hr_next [HSTAGES];
  rank_t          hr [HSTAGES];
  digit_vec_t     hd [HSTAGES];
  logic           hb [HSTAGES];

  // Write configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      tile_list   <= '0;
      pattern_len <= K_W'(1);
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_GROUP_TILES: tile_list   <= cfg_data;
        CFG_GROUP_SIZE:  pattern_len <= cfg_data[K_W-1:0];
        default: ;
      endcase
    end
  end

  // Saturate the group size to the board size
  assign k_eff = (pattern_len > K_W'(CELLS)) ? K_W'(CELLS) : pattern_len;

  // Load enables: a stage advances when empty or when the next one advances
  always_comb begin
    en[NST-1] = !vld[NST-1] || !out_stall;
    for (int s = NST - 2; s >= 0; s--) begin
      en[s] = !vld[s] || en[s+1];
    end
  end

  assign in_stall = !en[0];

  // Locate each tile; the highest cell holding a value wins
  always_comb begin
    logic [NIB-1:0]   v;
    logic [CELLS-1:0] seen;
    seen = '0;
    v    = '0;
    for (int t = 0; t < TILE_SLOTS; t++) begin
      cell_of_next[t] = '0;
    end
    for (int p = 0; p < CELLS; p++) begin
      v = board_state[NIB*p +: NIB];
      if (int'(v) < CELLS) begin
        cell_of_next[v] = cell_t'(p);
        seen[v]         = 1'b1;
      end
    end
    bad_next = (seen != {CELLS{1'b1}});
  end

  // Form every digit: cell minus the distinct earlier group cells below it
  always_comb begin
    cell_t            cellc  [CELLS];
    logic [CELLS-1:0] onehot [CELLS];
    logic [CELLS-1:0] used;
    logic [CELLS-1:0] below;
    used  = '0;
    below = '0;
    for (int i = 0; i < CELLS; i++) begin
      cellc[i]  = s1_cell_of[tile_list[NIB*i +: NIB]];
      onehot[i] = CELLS'(1) << cellc[i];
    end
    for (int i = 0; i < CELLS; i++) begin
      used = '0;
      for (int j = 0; j < i; j++) begin
        used = used | onehot[j];
      end
      below         = used & (onehot[i] - CELLS'(1));
      digit_next[i] = cellc[i] - cell_t'($countones(below));
    end
  end

  // Fold digits into the rank, a fixed slice of positions per stage
  always_comb begin
    rank_t      r;
    digit_vec_t d;
    for (int h = 0; h < HSTAGES; h++) begin
      if (h == 0) begin
        r = '0;
        d = s2_digit;
      end else begin
        r = hr[h-1];
        d = hd[h-1];
      end
      for (int t = 0; t < STEPS_PER_STAGE; t++) begin
        if (h * STEPS_PER_STAGE + t < CELLS) begin
          r = horner_step(r, d[h*STEPS_PER_STAGE + t],
                          unsigned'(h * STEPS_PER_STAGE + t), k_eff);
        end
      end
      hr_next[h] = r;
    end
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= in_valid;
      end
      for (int s = 1; s < NST; s++) begin
        if (en[s]) begin
          vld[s] <= vld[s-1];
        end
      end
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_cell_of <= cell_of_next;
      s1_bad     <= bad_next;
    end
    if (en[1]) begin
      s2_digit <= digit_next;
      s2_bad   <= s1_bad;
    end
    for (int h = 0; h < HSTAGES; h++) begin
      if (en[2+h]) begin
        hr[h] <= hr_next[h];
        if (h == 0) begin
          hd[h] <= s2_digit;
          hb[h] <= s2_bad;
        end else begin
          hd[h] <= hd[h-1];
          hb[h] <= hb[h-1];
        end
      end
    end
  end

  // Drive the result
  assign out_valid  = vld[NST-1];
  assign group_rank = hr[HSTAGES-1];
  assign bad_state  = hb[HSTAGES-1];

  // Checks
  a_stall_needs_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> vld[0])
    else $error("input stalled with first stage empty");

  a_free_out_no_stall: assert property (@(posedge clk) disable iff (rst)
    !out_stall |-> !in_stall)
    else $error("input stalled while output free");

  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> vld[0])
    else $error("accepted board missing from first stage");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (vld[NST-1] && !en[NST-1]) |=> vld[NST-1])
    else $error("stalled result lost");

endmodule

### tb/testbench.sv
// Self-checking testbench for the partial permutation ranker: directed and random boards.
module testbench;
  import ppr_pkg::*;

  localparam int TIMEOUT_CYCLES  = 400000;
  localparam int HOLD_OFF_CYCLES = 90;
  localparam int PHASES          = 12;
  localparam int PHASE_ITEMS     = 100;

  localparam logic [BOARD_W-1:0] IDENTITY_BOARD = 64'hFEDCBA9876543210;
  localparam logic [BOARD_W-1:0] REVERSED_BOARD = 64'h0123456789ABCDEF;

  typedef struct packed {
    rank_t rank;
    logic  bad;
  } rank_result_t;

  typedef enum logic [1:0] {RX_FREE, RX_LIGHT, RX_HEAVY, RX_PATTERN} rx_mode_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic [0:0]         cfg_index = CFG_GROUP_TILES;
  logic [BOARD_W-1:0] cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [BOARD_W-1:0] board_state = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [RANK_W-1:0]  group_rank;
  logic               bad_state;

  // Shadow copy of the configuration, as reset leaves it
  logic [BOARD_W-1:0] tile_reg = '0;
  grp_size_t          size_reg = K_W'(1);

  rank_result_t expected_results[$];
  int unsigned  mismatch_count = 0;
  int unsigned  cycle_count = 0;

  // Sender and receiver pacing
  bit          gaps_on = 1'b1;
  int unsigned burst_left = 0;
  bit          hold_request = 1'b0;
  int unsigned hold_left = 0;
  rx_mode_t    rx_mode = RX_FREE;
  int unsigned mode_left = 0;
  int unsigned pattern_phase = 0;

  partial_permutation_rank dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .board_state(board_state),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .group_rank (group_rank),
    .bad_state  (bad_state)
  );

  always #4 clk = ~clk;

  // Locate each tile, then fold the group's Lehmer digits into the rank
  function automatic rank_result_t predict_rank(logic [BOARD_W-1:0] board,
                                                logic [BOARD_W-1:0] tiles, grp_size_t size);
    cell_t        cell_of [TILE_SLOTS];
    logic [15:0]  seen;
    logic [15:0]  used;
    logic [63:0]  acc;
    cell_t        value;
    cell_t        tile;
    cell_t        pos;
    int unsigned  below;
    int unsigned  k;
    rank_result_t res;
    seen = '0;
    used = '0;
    acc  = '0;
    for (int i = 0; i < TILE_SLOTS; i++) cell_of[i] = '0;
    for (int p = 0; p < CELLS; p++) begin
      value = board[4*p +: 4];
      if (int'(value) < CELLS) begin
        cell_of[value] = cell_t'(p);
        seen[value]    = 1'b1;
      end
    end
    k = (int'(size) > CELLS) ? CELLS : int'(size);
    for (int i = 0; i < k; i++) begin
      tile  = tiles[4*i +: 4];
      pos   = cell_of[tile];
      below = 0;
      for (int j = 0; j < int'(pos); j++) if (used[j]) below++;
      acc = acc * 64'(CELLS - i) + 64'(int'(pos) - below);
      used[pos] = 1'b1;
    end
    res.rank = acc[RANK_W-1:0];
    res.bad  = (seen != 16'hFFFF);
    return res;
  endfunction

  function automatic logic [BOARD_W-1:0] random_perm();
    cell_t              vals [CELLS];
    cell_t              tmp;
    int unsigned        j;
    logic [BOARD_W-1:0] b;
    for (int i = 0; i < CELLS; i++) vals[i] = cell_t'(i);
    for (int i = CELLS - 1; i > 0; i--) begin
      j       = $urandom_range(0, i);
      tmp     = vals[i];
      vals[i] = vals[j];
      vals[j] = tmp;
    end
    for (int i = 0; i < CELLS; i++) b[4*i +: 4] = vals[i];
    return b;
  endfunction

  // Mostly legal boards; some with a duplicate, a stray nibble or pure noise
  function automatic logic [BOARD_W-1:0] random_board();
    logic [BOARD_W-1:0] b;
    int unsigned        pick;
    int unsigned        a;
    int unsigned        c;
    b    = random_perm();
    pick = $urandom_range(0, 99);
    a    = $urandom_range(0, 15);
    c    = $urandom_range(0, 15);
    if (pick >= 96) b = {$urandom, $urandom};
    else if (pick >= 90) b[4*a +: 4] = b[4*c +: 4];
    else if (pick >= 84) b[4*a +: 4] = 4'($urandom);
    return b;
  endfunction

  task automatic log_mismatch(string what);
    mismatch_count++;
    if (mismatch_count <= 10) $display("MISMATCH at cycle %0d: %s", cycle_count, what);
  endtask

  // Offer one board, pausing between bursts, and hold it until the transfer
  task automatic send_board(logic [BOARD_W-1:0] board);
    int unsigned gap;
    if (gaps_on) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        if (gap != 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      burst_left--;
    end
    in_valid    <= 1'b1;
    board_state <= board;
    do @(posedge clk); while (in_stall);
  endtask

  // Stop offering and wait until every expected result has been taken
  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  // Write both registers while the pipeline is empty
  task automatic set_config(logic [BOARD_W-1:0] tiles, logic [BOARD_W-1:0] size);
    wait_for_results();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_GROUP_TILES;
    cfg_data  <= tiles;
    @(posedge clk);
    cfg_index <= CFG_GROUP_SIZE;
    cfg_data  <= size;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic test_reset_values();
    send_board(IDENTITY_BOARD);
    send_board(REVERSED_BOARD);
    send_board(random_perm());
  endtask

  task automatic test_directed_boards();
    // Full identity group: smallest and largest rank, then broken boards
    set_config(IDENTITY_BOARD, 16);
    send_board(IDENTITY_BOARD);
    send_board(REVERSED_BOARD);
    send_board('0);
    send_board('1);
    send_board(64'hFEDCBA9876547210);
    // Empty group, then oversized group counts that saturate
    set_config(IDENTITY_BOARD, 0);
    send_board(IDENTITY_BOARD);
    send_board(REVERSED_BOARD);
    set_config(IDENTITY_BOARD, 31);
    send_board(REVERSED_BOARD);
    set_config(IDENTITY_BOARD, 17);
    send_board(REVERSED_BOARD);
    // Repeated group tiles let digits exceed their base
    set_config(64'h5555555555555555, 16);
    send_board(random_perm());
    set_config('1, 5);
    send_board(REVERSED_BOARD);
    set_config('0, 1);
    send_board('0);
  endtask

  // Long receiver hold-off with the sender pushing back to back
  task automatic test_receiver_hold_off();
    set_config(random_perm(), 16);
    gaps_on      = 1'b0;
    hold_request = 1'b1;
    repeat (40) send_board(random_perm());
    gaps_on = 1'b1;
    wait_for_results();
  endtask

  task automatic test_random_phases();
    logic [BOARD_W-1:0] tiles;
    logic [BOARD_W-1:0] size;
    for (int phase = 0; phase < PHASES; phase++) begin
      tiles = ($urandom_range(0, 3) != 0) ? random_perm() : {$urandom, $urandom};
      case ($urandom_range(0, 3))
        0:       size = 16;
        1:       size = 64'($urandom_range(1, 16));
        2:       size = {$urandom, $urandom};
        default: size = 1;
      endcase
      set_config(tiles, size);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n == PHASE_ITEMS / 2 && phase % 3 == 0) wait_for_results();
        send_board(random_board());
      end
    end
  endtask

  // Receiver: long hold-off on request, otherwise a changing stall pattern
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (hold_request) begin
      hold_request = 1'b0;
      hold_left    = HOLD_OFF_CYCLES;
      out_stall   <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        rx_mode   = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 200);
      end
      mode_left--;
      pattern_phase++;
      case (rx_mode)
        RX_FREE:  out_stall <= 1'b0;
        RX_LIGHT: out_stall <= ($urandom_range(0, 2) == 0);
        RX_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
        default:  out_stall <= (pattern_phase % 5) < 2;
      endcase
    end
  end

  // Check each result transfer, then predict for each board transfer
  always @(posedge clk) begin : monitor
    rank_result_t want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          log_mismatch($sformatf("unexpected result rank %0d bad %0b", group_rank, bad_state));
        end else begin
          want = expected_results.pop_front();
          if (group_rank !== want.rank)
            log_mismatch($sformatf("group_rank expected %0d got %0d", want.rank, group_rank));
          if (bad_state !== want.bad)
            log_mismatch($sformatf("bad_state expected %0b got %0b", want.bad, bad_state));
        end
      end
      if (in_valid && !in_stall)
        expected_results.push_back(predict_rank(board_state, tile_reg, size_reg));
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          CFG_GROUP_TILES: tile_reg = cfg_data;
          default:         size_reg = cfg_data[K_W-1:0];
        endcase
      end
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > TIMEOUT_CYCLES) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_values();
    test_directed_boards();
    test_receiver_hold_off();
    test_random_phases();
    wait_for_results();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/ppr_pkg.sv
hw/rtl/partial_permutation_rank.sv
tb/testbench.sv
